// ----- src/flg_pkg.sv -----
`default_nettype none
package flg_pkg;

	// Delay line geometry and sample format.
	localparam int BUFFER_DEPTH = 1024;
	localparam int SAMPLE_BITS  = 24;
	localparam int AW           = $clog2(BUFFER_DEPTH);

	// Configuration register indexes.
	localparam logic [1:0] REG_FEEDBACK_GAIN = 2'd0;
	localparam logic [1:0] REG_LFO_STEP      = 2'd1;
	localparam logic [1:0] REG_BASE_DELAY    = 2'd2;
	localparam logic [1:0] REG_LFO_AMPLITUDE = 2'd3;

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 22;

	// LFO phase is Q1.23; the unreflected sum needs two more bits.
	localparam int PHASE_W    = 25;
	localparam int PHASE_FRAC = 23;
	localparam int PSUM_W     = 27;

	// Shared multiplier: signed A by signed B, registered product.
	localparam int MUL_A_W = (SAMPLE_BITS + 1 > PHASE_W) ? SAMPLE_BITS + 1 : PHASE_W;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Mix gain of 0.7 in Q0.16.
	localparam logic signed [MUL_B_W-1:0] MIX_GAIN = MUL_B_W'(45875);

	typedef struct packed {
		logic                      en;
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

	// Clamp a wide signed value to the sample range.
	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [MUL_P_W-1:0] v
	);
		logic signed [MUL_P_W-1:0] hi;
		logic signed [MUL_P_W-1:0] lo;
		hi = MUL_P_W'($signed({1'b0, {(SAMPLE_BITS-1){1'b1}}}));
		lo = -hi - MUL_P_W'(1);
		if (v > hi) begin
			return SAMPLE_BITS'(hi);
		end else if (v < lo) begin
			return SAMPLE_BITS'(lo);
		end
		return SAMPLE_BITS'(v);
	endfunction

endpackage
`default_nettype wire

// ----- src/flg_mul.sv -----
`default_nettype none
// Shared signed multiplier with a registered product; the product holds
// until the next request.
module flg_mul (
	input  wire logic                               clk,
	input  wire flg_pkg::mul_req_t                  req,
	output logic signed [flg_pkg::MUL_P_W-1:0]      prod
);

	logic signed [flg_pkg::MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= req.a * req.b;
		end
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

// ----- src/flanger_triangle_lfo_delay_core.sv -----
// The sequencer takes one sample at a time and accepts no new sample until it is
// back in idle. It runs every multiplication through one shared multiplier and
// both taps through one RAM port; a result that is not taken holds the sequencer
// in its mix step. Reset: asynchronous, active low; the delay line needs no
// clearing pass, since a fill count makes slots not yet written read as zero.
`default_nettype none
module flanger_triangle_lfo_delay_core (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cfg_wr_en,
	input  wire logic [flg_pkg::CFG_AW-1:0]               cfg_addr,
	input  wire logic [flg_pkg::CFG_DW-1:0]               cfg_wdata,
	input  wire logic                                     in_valid,
	output logic                                          in_ready,
	input  wire logic signed [flg_pkg::SAMPLE_BITS-1:0]   sample_in,
	output logic                                          out_valid,
	input  wire logic                                     out_ready,
	output logic signed [flg_pkg::SAMPLE_BITS-1:0]        sample_out
);

	localparam int SB    = flg_pkg::SAMPLE_BITS;
	localparam int AW    = flg_pkg::AW;
	localparam int DEPTH = flg_pkg::BUFFER_DEPTH;
	localparam int PW    = flg_pkg::MUL_P_W;
	localparam int AWID  = flg_pkg::MUL_A_W;
	localparam int BWID  = flg_pkg::MUL_B_W;
	localparam int PS_W  = flg_pkg::PSUM_W;
	localparam int PH_W  = flg_pkg::PHASE_W;
	// Width of the signed delay sum before clamping.
	localparam int DW    = (AW + 9 > 20) ? AW + 9 : 20;

	localparam logic signed [PS_W-1:0] PHASE_ONE = PS_W'(8388608);
	localparam logic signed [PS_W-1:0] PHASE_TWO = PS_W'(16777216);
	localparam logic signed [DW-1:0]   ONE_SMP   = DW'(256);
	localparam logic signed [DW-1:0]   DLY_MAX   = DW'((DEPTH - 1) * 256);
	localparam logic [AW:0]            DEPTH_C   = (AW + 1)'(DEPTH);

	// The sequencer. Each state uses the multiplier or the RAM port at most once.
	typedef enum logic [3:0] {
		ST_IDLE,   // wait for a sample; form the raw phase sum
		ST_LFO,    // reflect the phase at plus and minus one
		ST_OFS,    // multiply phase by swing
		ST_DLY,    // form and clamp the delay
		ST_RDA,    // read the older-by-n tap
		ST_RDB,    // read the next tap
		ST_INT,    // difference between the taps
		ST_MULF,   // scale the difference by the fraction
		ST_RD,     // interpolated read value
		ST_FB,     // feedback multiply
		ST_WR,     // write the line, start the mix multiply
		ST_MIX     // saturate the mix into the output register
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0] fb_gain_q;
	logic [21:0] step_q;
	logic [16:0] base_q;
	logic [16:0] swing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_gain_q <= 16'd12714;
			step_q    <= 22'd210;
			base_q    <= 17'd64819;
			swing_q   <= 17'd58337;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				flg_pkg::REG_FEEDBACK_GAIN: fb_gain_q <= cfg_wdata[15:0];
				flg_pkg::REG_LFO_STEP:      step_q    <= cfg_wdata[21:0];
				flg_pkg::REG_BASE_DELAY:    base_q    <= cfg_wdata[16:0];
				flg_pkg::REG_LFO_AMPLITUDE: swing_q   <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	// Working registers of one transaction.
	logic signed [SB-1:0]   x_q;
	logic signed [PS_W-1:0] psum_q;
	logic [16:0]            amp_q;
	logic signed [PH_W-1:0] phase_q;
	logic                   dir_q;
	logic [AW+7:0]          dly_q;
	logic [AW-1:0]          ib_q;
	logic                   va_q;
	logic                   vb_q;
	logic signed [SB-1:0]   a_q;
	logic signed [SB:0]     diff_q;
	logic signed [SB-1:0]   rd_q;
	logic signed [SB:0]     xr_q;
	logic [AW-1:0]          wp_q;
	logic [AW:0]            fill_q;
	logic                   out_valid_q;
	logic signed [SB-1:0]   out_q;

	// Delay line RAM and its registered read data.
	logic signed [SB-1:0]   mem [DEPTH];
	logic signed [SB-1:0]   rdata_q;
	logic                   mem_we;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic signed [SB-1:0]   wr_data;

	// Shared multiplier.
	flg_pkg::mul_req_t      mul_req;
	logic signed [PW-1:0]   mul_p;

	flg_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (mul_p)
	);

	// Address wrap for a sum known to stay below twice the depth.
	function automatic logic [AW-1:0] wrap_addr(input logic [AW:0] s);
		if (s >= DEPTH_C) begin
			return AW'(s - DEPTH_C);
		end
		return AW'(s);
	endfunction

	logic                   in_acc;
	logic signed [PS_W-1:0] psum_next;
	logic signed [DW-1:0]   ofs;
	logic signed [DW-1:0]   dly_sum;
	logic [AW-1:0]          n_int;
	logic [AW:0]            n_ext;
	logic [AW:0]            n_ext1;
	logic signed [PW-1:0]   wr_sum;
	logic signed [SB-1:0]   b_val;

	assign in_acc    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign sample_out = out_q;

	assign psum_next = dir_q ? (PS_W'(phase_q) - $signed(PS_W'(step_q)))
	                         : (PS_W'(phase_q) + $signed(PS_W'(step_q)));

	// The offset is the product shifted down with floor rounding.
	assign ofs     = DW'(mul_p >>> flg_pkg::PHASE_FRAC);
	assign dly_sum = ONE_SMP + $signed(DW'(base_q)) + ofs;

	assign n_int   = dly_q[AW+7:8];
	assign n_ext   = {1'b0, n_int};
	assign n_ext1  = n_ext + (AW + 1)'(1);

	assign wr_sum  = PW'(x_q) + (mul_p >>> 16);
	assign wr_data = flg_pkg::sat_sample(wr_sum);
	assign b_val   = vb_q ? rdata_q : '0;

	assign mem_we  = (state_q == ST_WR);
	assign rd_en   = (state_q == ST_RDA) || (state_q == ST_RDB);
	assign rd_addr = (state_q == ST_RDA) ? wrap_addr({1'b0, wp_q} + n_ext) : ib_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Multiplier operand selection.
	always_comb begin
		mul_req.en = 1'b0;
		mul_req.a  = '0;
		mul_req.b  = '0;
		case (state_q)
			ST_OFS: begin
				mul_req.en = 1'b1;
				mul_req.a  = AWID'(phase_q);
				mul_req.b  = $signed(BWID'(amp_q));
			end
			ST_MULF: begin
				mul_req.en = 1'b1;
				mul_req.a  = AWID'(diff_q);
				mul_req.b  = $signed(BWID'(dly_q[7:0]));
			end
			ST_FB: begin
				mul_req.en = 1'b1;
				mul_req.a  = AWID'(rd_q);
				mul_req.b  = $signed(BWID'(fb_gain_q));
			end
			ST_WR: begin
				mul_req.en = 1'b1;
				mul_req.a  = AWID'(xr_q);
				mul_req.b  = flg_pkg::MIX_GAIN;
			end
			default: ;
		endcase
	end

	// Control state, LFO state, pointers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			dir_q       <= 1'b0;
			wp_q        <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			x_q         <= '0;
			psum_q      <= '0;
			amp_q       <= '0;
			dly_q       <= '0;
			ib_q        <= '0;
			va_q        <= 1'b0;
			vb_q        <= 1'b0;
			a_q         <= '0;
			diff_q      <= '0;
			rd_q        <= '0;
			xr_q        <= '0;
			out_q       <= '0;
		end else begin
			// The mix step sets the flag itself when it hands over a new result.
			if (out_valid_q && out_ready && (state_q != ST_MIX)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						x_q     <= sample_in;
						psum_q  <= psum_next;
						amp_q   <= (swing_q < base_q) ? swing_q : base_q;
						state_q <= ST_LFO;
					end
				end
				ST_LFO: begin
					// Reflection at either end reverses the sweep.
					if (psum_q > PHASE_ONE) begin
						phase_q <= PH_W'(PHASE_TWO - psum_q);
						dir_q   <= ~dir_q;
					end else if (psum_q < -PHASE_ONE) begin
						phase_q <= PH_W'(-PHASE_TWO - psum_q);
						dir_q   <= ~dir_q;
					end else begin
						phase_q <= PH_W'(psum_q);
					end
					state_q <= ST_OFS;
				end
				ST_OFS: begin
					state_q <= ST_DLY;
				end
				ST_DLY: begin
					if (dly_sum > DLY_MAX) begin
						dly_q <= (AW + 8)'(DLY_MAX);
					end else if (dly_sum[DW-1]) begin
						dly_q <= '0;
					end else begin
						dly_q <= (AW + 8)'(dly_sum);
					end
					state_q <= ST_RDA;
				end
				ST_RDA: begin
					// A slot m writes back was written only if that many writes
					// have happened; otherwise its read data is taken as zero.
					ib_q    <= wrap_addr({1'b0, wp_q} + n_ext1);
					va_q    <= (fill_q >= n_ext);
					vb_q    <= (fill_q >= n_ext1);
					state_q <= ST_RDB;
				end
				ST_RDB: begin
					a_q     <= va_q ? rdata_q : '0;
					state_q <= ST_INT;
				end
				ST_INT: begin
					diff_q  <= (SB + 1)'(b_val) - (SB + 1)'(a_q);
					state_q <= ST_MULF;
				end
				ST_MULF: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					rd_q    <= SB'(PW'(a_q) + (mul_p >>> 8));
					state_q <= ST_FB;
				end
				ST_FB: begin
					xr_q    <= (SB + 1)'(x_q) + (SB + 1)'(rd_q);
					state_q <= ST_WR;
				end
				ST_WR: begin
					wp_q    <= (wp_q == '0) ? AW'(DEPTH - 1) : wp_q - AW'(1);
					if (fill_q != DEPTH_C) begin
						fill_q <= fill_q + (AW + 1)'(1);
					end
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					// Wait here while an earlier result has not been taken.
					if (!out_valid_q || out_ready) begin
						out_q       <= flg_pkg::sat_sample(mul_p >>> 16);
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// An accepted sample keeps the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input accepted while a sample was still in work");

	// A new result appears only out of the mix step.
	a_result_from_mix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_MIX))
		else $error("result raised outside the mix step");

	// The fill count never runs past the depth of the line.
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill count beyond buffer depth");

endmodule
`default_nettype wire

// ----- sim/tb_flanger_triangle_lfo_delay_core.sv -----
`timescale 1ns / 100ps

// Testbench for the flanger core: a triangle LFO sweeps a fractional delay tap
// over a 1024-entry delay line, the tap is fed back into the line and mixed with
// the dry input at a gain of 0.7.
//
// The bench keeps its own bit-accurate copy of the flanger state (delay line,
// write index, LFO position and direction, and the four settings). Each input
// transaction is run through this copy at the moment it is accepted. The
// predicted sample is queued, and every output transaction is checked against
// the head of that queue.
//
// The run has two parts. A short table of directed rows comes first. It holds
// samples at the extremes, plus settings rows that reach the corner cases: a
// step so large that the LFO bounces off both rails, a delay long enough to
// hit the end of the line, a swing wider than the center delay, and a center
// delay below its nominal minimum. Random phases follow. Each one first lets
// the core go idle, then loads fresh settings and streams random audio.
// Handshake gaps and output back-pressure change from phase to phase.
module tb_flanger_triangle_lfo_delay_core;

	import flg_pkg::*;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef enum logic {ROW_SAMPLE, ROW_SETTINGS} row_kind_t;

	// One directed row holds either an audio sample, with an optional
	// hand-computed result, or a complete set of register values.
	typedef struct packed {
		row_kind_t         kind;
		sample_t           smp;
		logic              typed;
		sample_t           want;
		logic [CFG_DW-1:0] fb;
		logic [CFG_DW-1:0] step;
		logic [CFG_DW-1:0] base;
		logic [CFG_DW-1:0] amp;
	} stim_row_t;

	localparam sample_t SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam longint PHASE_ONE = longint'(1) <<< PHASE_FRAC;
	localparam longint DELAY_MAX = longint'(BUFFER_DEPTH - 1) * 256;
	localparam int RANDOM_ITEMS = 2000;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 30;
	localparam int DIRECTED_ROWS = 26;

	// Right after reset the delay line is empty and the tap is far back, so
	// each output is simply floor(x * 45875 / 65536). The first five rows carry
	// that value written out by hand.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_SAMPLE, 24'sd8388607, 1'b1, 24'sd5871999, '0, '0, '0, '0},
		'{ROW_SAMPLE, -24'sd8388608, 1'b1, -24'sd5872000, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'sd0, 1'b1, 24'sd0, '0, '0, '0, '0},
		'{ROW_SAMPLE, -24'sd1, 1'b1, -24'sd1, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'sd1, 1'b1, 24'sd0, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'sh555555, 1'b0, '0, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'shAAAAAA, 1'b0, '0, '0, '0, '0, '0},
		// Largest step, longest center delay and widest swing. The LFO bounces
		// off both rails and the tap clips at the end of the line.
		'{ROW_SETTINGS, '0, 1'b0, '0, 22'h00FFFF, 22'h3FFFFF, 22'h01FFFF, 22'h01FFFF},
		'{ROW_SAMPLE, 24'sh7FFFFF, 1'b0, '0, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'sh800000, 1'b0, '0, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'sh7FFFFF, 1'b0, '0, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'sh7FFFFF, 1'b0, '0, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'sh800000, 1'b0, '0, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'sd12345, 1'b0, '0, '0, '0, '0, '0},
		// The center delay is below its nominal minimum and the swing is wider
		// than the center, so the tap must stop at one sample.
		'{ROW_SETTINGS, '0, 1'b0, '0, 22'h000000, 22'h200000, 22'h00012C, 22'h01FFFF},
		'{ROW_SAMPLE, 24'sh400000, 1'b0, '0, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'shC00000, 1'b0, '0, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'sh7FFFFF, 1'b0, '0, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'sh800000, 1'b0, '0, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'sd777, 1'b0, '0, '0, '0, '0, '0},
		// The LFO is frozen, there is no swing, the center delay is at its
		// minimum and the feedback gain is at its nominal maximum.
		'{ROW_SETTINGS, '0, 1'b0, '0, 22'h00F852, 22'h000000, 22'h0004CD, 22'h000000},
		'{ROW_SAMPLE, 24'sh7FFFFF, 1'b0, '0, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'sh7FFFFF, 1'b0, '0, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'sh800000, 1'b0, '0, '0, '0, '0, '0},
		'{ROW_SAMPLE, 24'sd0, 1'b0, '0, '0, '0, '0, '0},
		'{ROW_SAMPLE, -24'sd1, 1'b0, '0, '0, '0, '0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_DW-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	sample_t sample_in;
	logic out_valid;
	logic out_ready;
	sample_t sample_out;

	// Bench copy of the flanger state and settings.
	sample_t line_mem [BUFFER_DEPTH];
	logic [AW-1:0] line_wr_idx;
	longint lfo_pos;
	logic lfo_falling;
	logic [15:0] gain_q16;
	logic [21:0] lfo_inc;
	logic [16:0] center_dly;
	logic [16:0] swing_lim;

	sample_t mix_expect_q[$];
	sample_t rx_want;
	int unsigned mix_errors = 0;
	int unsigned in_idle_pct = 0;
	int unsigned out_idle_pct = 0;
	int unsigned rx_hold = 0;
	int unsigned quiet_cycles = 0;
	int unsigned samples_sent = 0;
	int unsigned phase_len;

	flanger_triangle_lfo_delay_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic sample_t clamp_sample(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return sample_t'(hi);
		end else if (v < lo) begin
			return sample_t'(lo);
		end
		return sample_t'(v);
	endfunction

	// Runs one sample through the bench copy of the flanger. It advances the
	// LFO, reads the interpolated tap and writes the feedback sum into the
	// line. It returns the wet/dry mix.
	function automatic sample_t flange_sample(input sample_t x_in);
		longint x;
		longint pos;
		longint swing;
		longint dly;
		longint frac;
		longint tap_a;
		longint tap_b;
		longint tap;
		logic [AW-1:0] ia;
		logic [AW-1:0] ib;
		x = longint'(x_in);
		pos = lfo_falling ? lfo_pos - longint'(lfo_inc) : lfo_pos + longint'(lfo_inc);
		// The triangle folds back at either rail and changes direction.
		if (pos > PHASE_ONE) begin
			pos = 2 * PHASE_ONE - pos;
			lfo_falling = ~lfo_falling;
		end else if (pos < -PHASE_ONE) begin
			pos = -2 * PHASE_ONE - pos;
			lfo_falling = ~lfo_falling;
		end
		lfo_pos = pos;
		swing = (swing_lim < center_dly) ? longint'(swing_lim) : longint'(center_dly);
		dly = 256 + longint'(center_dly) + ((lfo_pos * swing) >>> PHASE_FRAC);
		if (dly > DELAY_MAX) begin
			dly = DELAY_MAX;
		end
		if (dly < 0) begin
			dly = 0;
		end
		frac = dly & 255;
		ia = line_wr_idx + AW'(dly >>> 8);
		ib = ia + 1'b1;
		tap_a = longint'(line_mem[ia]);
		tap_b = longint'(line_mem[ib]);
		tap = tap_a + (((tap_b - tap_a) * frac) >>> 8);
		line_mem[line_wr_idx] = clamp_sample(x + ((tap * longint'(gain_q16)) >>> 16));
		line_wr_idx = line_wr_idx - 1'b1;
		return clamp_sample(((x + tap) * longint'(MIX_GAIN)) >>> 16);
	endfunction

	// Most gaps are short, and about one in ten is long.
	function automatic int unsigned pick_gap(input int unsigned pct);
		if (pct == 0 || $urandom_range(0, 99) >= pct) begin
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(20, 80);
		end
		return $urandom_range(1, 4);
	endfunction

	function automatic int unsigned pick_idle_pct();
		case ($urandom_range(0, 2))
			0: begin
				return 0;
			end
			1: begin
				return 25;
			end
			default: begin
				return 60;
			end
		endcase
	endfunction

	// Picks a register value. It favors the all-zero and all-one values, the
	// nominal range limits and the reset value. Now and then it sets junk
	// above the register's width, which the core must drop.
	function automatic logic [CFG_DW-1:0] pick_reg_value(input int unsigned w,
			input int unsigned lo, input int unsigned hi, input int unsigned rst);
		logic [CFG_DW-1:0] mask;
		logic [CFG_DW-1:0] v;
		mask = (CFG_DW'(1) << w) - 1'b1;
		case ($urandom_range(0, 7))
			0: begin
				v = '0;
			end
			1: begin
				v = mask;
			end
			2: begin
				v = CFG_DW'(lo);
			end
			3: begin
				v = CFG_DW'(hi);
			end
			4: begin
				v = CFG_DW'(rst);
			end
			5, 6: begin
				v = CFG_DW'($urandom_range(hi, lo));
			end
			default: begin
				v = CFG_DW'($urandom()) & mask;
			end
		endcase
		if ($urandom_range(0, 3) == 0) begin
			v |= CFG_DW'($urandom()) & ~mask;
		end
		return v;
	endfunction

	function automatic sample_t random_sample();
		case ($urandom_range(0, 9))
			0: begin
				return SMP_MAX;
			end
			1: begin
				return SMP_MIN;
			end
			2, 3, 4: begin
				return sample_t'($signed($urandom()) >>> $urandom_range(8, 31));
			end
			default: begin
				return sample_t'($urandom());
			end
		endcase
	endfunction

	// Offers one sample and holds it until the core takes it. The sample is
	// run through the bench copy on the accepting edge. A gap of zero keeps
	// in_valid high from one transaction to the next.
	task automatic drive_sample(input sample_t s, input logic typed, input sample_t want);
		int unsigned gap;
		sample_t mix;
		gap = pick_gap(in_idle_pct);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		mix = flange_sample(s);
		mix_expect_q.push_back(typed ? want : mix);
	endtask

	// Stops offering input and waits until every output has come back, so
	// the core is idle.
	task automatic await_idle();
		in_valid <= 1'b0;
		while (mix_expect_q.size() != 0) @(posedge clk);
	endtask

	// Writes all four registers back to back. Each value goes into the bench
	// copy on the edge that writes it into the core.
	task automatic apply_settings(input logic [CFG_DW-1:0] fb, input logic [CFG_DW-1:0] step,
			input logic [CFG_DW-1:0] base, input logic [CFG_DW-1:0] amp);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= REG_FEEDBACK_GAIN;
		cfg_wdata <= fb;
		@(posedge clk);
		gain_q16  = fb[15:0];
		cfg_addr  <= REG_LFO_STEP;
		cfg_wdata <= step;
		@(posedge clk);
		lfo_inc   = step[21:0];
		cfg_addr  <= REG_BASE_DELAY;
		cfg_wdata <= base;
		@(posedge clk);
		center_dly = base[16:0];
		cfg_addr  <= REG_LFO_AMPLITUDE;
		cfg_wdata <= amp;
		@(posedge clk);
		swing_lim = amp[16:0];
		cfg_wr_en <= 1'b0;
	endtask

	// Output side. It checks each output transaction against the oldest
	// prediction and applies random back-pressure.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (mix_expect_q.size() == 0) begin
				$error("sample_out: unexpected transaction, got %0d", sample_out);
				mix_errors++;
			end else begin
				rx_want = mix_expect_q.pop_front();
				if (sample_out !== rx_want) begin
					$error("sample_out mismatch: expected %0d, got %0d", rx_want, sample_out);
					mix_errors++;
				end
			end
		end
		if (rx_hold != 0) begin
			out_ready <= 1'b0;
			rx_hold--;
		end else begin
			rx_hold = pick_gap(out_idle_pct);
			out_ready <= (rx_hold == 0);
			if (rx_hold != 0) begin
				rx_hold--;
			end
		end
	end

	// Watchdog. The run ends if neither side completes a transaction for too
	// long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_addr  <= REG_FEEDBACK_GAIN;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		sample_in <= '0;

		// The bench copy starts from the reset state of the core.
		for (int i = 0; i < BUFFER_DEPTH; i++) begin
			line_mem[i] = '0;
		end
		line_wr_idx = '0;
		lfo_pos     = 0;
		lfo_falling = 1'b0;
		gain_q16    = 16'd12714;
		lfo_inc     = 22'd210;
		center_dly  = 17'd64819;
		swing_lim   = 17'd58337;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with some idling on both sides.
		in_idle_pct  = 25;
		out_idle_pct = 25;
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (directed_rows[r].kind == ROW_SETTINGS) begin
				await_idle();
				apply_settings(directed_rows[r].fb, directed_rows[r].step,
					directed_rows[r].base, directed_rows[r].amp);
			end else begin
				drive_sample(directed_rows[r].smp, directed_rows[r].typed, directed_rows[r].want);
			end
		end

		// Random phases. Each one starts from an idle core with new settings
		// and its own amount of idling. Some phases have no idling at all.
		while (samples_sent < RANDOM_ITEMS) begin
			await_idle();
			apply_settings(pick_reg_value(16, 0, 63570, 12714),
				pick_reg_value(22, 0, 2097152, 210),
				pick_reg_value(17, 1229, 130816, 64819),
				pick_reg_value(17, 0, 130816, 58337));
			in_idle_pct  = pick_idle_pct();
			out_idle_pct = pick_idle_pct();
			phase_len    = $urandom_range(60, 220);
			repeat (phase_len) begin
				drive_sample(random_sample(), 1'b0, '0);
				samples_sent++;
			end
		end

		// Drain the outputs. Then keep out_ready high for a while so that any
		// extra output transaction gets caught.
		await_idle();
		out_idle_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mix_errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
